// File: src/rmts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_pkg
// shared types and constants of the rate monotonic task scheduler
// ----------------------------------------------------------------------------
package rmts_pkg;
    localparam int MAX_TASKS_DEF = 16;
    localparam logic [19:0] LIMIT_RESET = 20'd693;
    localparam logic [15:0] SCALE_RESET = 16'd1000;
    localparam logic [9:0] PERMILLE = 10'd1000;

    localparam logic [1:0] OP_REG = 2'd0;
    localparam logic [1:0] OP_YIELD = 2'd1;
    localparam logic [1:0] OP_DEREG = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_OVER = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_ZERO = 3'd4;

    localparam logic [1:0] MODE_SLEEP = 2'd1;
    localparam logic [1:0] MODE_RUN = 2'd2;
    localparam logic [1:0] MODE_READY = 2'd3;

    localparam logic [0:0] CFG_LIMIT = 1'd0;
    localparam logic [0:0] CFG_SCALE = 1'd1;

    typedef struct packed {
        logic [1:0] op;
        logic [21:0] task_id;
        logic [15:0] period;
        logic [15:0] compute_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic running_valid;
        logic [21:0] running_id;
        logic dispatched;
        logic [4:0] tasks_used;
    } t_out_item;

    // command broadcast to every cell
    typedef struct packed {
        logic yield_en;
        logic dereg_en;
        logic tick_en;
        logic demote_en;
        logic [21:0] id;
        logic [31:0] now;
        logic [15:0] scale;
    } t_cell_cmd;
endpackage

// File: src/rmts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rmts_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [25:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [25:0] o_quot
);
    logic [25:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [16:0] w_try;

    always_comb begin
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_try = {r_rem[15:0], r_q[25]};
        if (i_start) begin
            n_q = i_num;
            n_rem = '0;
            n_cnt = 5'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_try >= {1'b0, i_den}) begin
                n_rem = w_try - {1'b0, i_den};
                n_q = {r_q[24:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_q = {r_q[24:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd25) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: src/rmts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_cell
// one task slot; passes a running best candidate and a load sum to its neighbor
// ----------------------------------------------------------------------------
module rmts_cell #(
    parameter int IDX_W = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IDX_W-1:0]      i_idx,
    input  rmts_pkg::t_cell_cmd   i_cmd,
    input  logic                  i_wr,
    input  logic [21:0]           i_wr_id,
    input  logic [15:0]           i_wr_period,
    input  logic [31:0]           i_wr_load,
    input  logic                  i_run,
    input  logic                  i_best_v,
    input  logic [15:0]           i_best_per,
    input  logic [IDX_W-1:0]      i_best_idx,
    input  logic [35:0]           i_sum,
    output logic                  o_best_v,
    output logic [15:0]           o_best_per,
    output logic [IDX_W-1:0]      o_best_idx,
    output logic [35:0]           o_sum,
    output logic                  o_valid,
    output logic                  o_match,
    output logic                  o_due,
    output logic                  o_running,
    output logic [21:0]           o_id
);
    import rmts_pkg::*;
    logic        r_valid, r_armed;
    logic [21:0] r_id;
    logic [15:0] r_period;
    logic [31:0] r_load, r_start, r_rel;
    logic [1:0]  r_mode;
    logic [31:0] w_pt, w_runt, w_diff;
    logic        w_ready;
    logic        r_bv;
    logic [15:0] r_bp;
    logic [IDX_W-1:0] r_bi;
    logic [35:0] r_sum;

    assign o_match = r_valid && (r_id == i_cmd.id);
    assign w_diff = i_cmd.now - r_rel;
    assign o_due = r_valid && r_armed && !w_diff[31];
    assign w_pt = 32'(r_period) * 32'(i_cmd.scale);
    assign w_runt = i_cmd.now - r_start;
    // the running task goes back to ready on dispatch, so it competes too
    assign w_ready = r_valid && (r_mode == MODE_READY || r_mode == MODE_RUN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
            r_bp <= '0;
            r_bi <= '0;
            r_sum <= '0;
        end else begin
            r_bv <= i_best_v;
            r_bp <= i_best_per;
            r_bi <= i_best_idx;
            if (w_ready && (!i_best_v || r_period < i_best_per)) begin
                r_bv <= 1'b1;
                r_bp <= r_period;
                r_bi <= i_idx;
            end
            r_sum <= i_sum + (r_valid ? {4'd0, r_load} : 36'd0);
        end
    end

    assign o_best_v = r_bv;
    assign o_best_per = r_bp;
    assign o_best_idx = r_bi;
    assign o_sum = r_sum;
    assign o_valid = r_valid;
    assign o_running = r_valid && (r_mode == MODE_RUN);
    assign o_id = r_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_armed <= 1'b0;
        end else if (i_wr) begin
            r_valid <= 1'b1;
            r_armed <= 1'b0;
        end else if (i_cmd.dereg_en && o_match) begin
            r_valid <= 1'b0;
            r_armed <= 1'b0;
        end else if (i_cmd.yield_en && o_match) begin
            r_armed <= 1'b1;
        end else if (i_cmd.tick_en && o_due) begin
            r_armed <= 1'b0;
        end
        if (i_wr) begin
            r_id <= i_wr_id;
            r_period <= i_wr_period;
            r_load <= i_wr_load;
            r_mode <= MODE_SLEEP;
            r_start <= '0;
            r_rel <= '0;
        end else if (i_cmd.yield_en && o_match) begin
            r_mode <= MODE_SLEEP;
            if (w_runt > w_pt || r_start == 32'd0)
                r_rel <= i_cmd.now + w_pt;
            else
                r_rel <= i_cmd.now + w_pt - w_runt;
        end else if (i_cmd.tick_en && o_due) begin
            r_mode <= MODE_READY;
        end else if (i_run) begin
            r_mode <= MODE_RUN;
            r_start <= i_cmd.now;
        end else if (i_cmd.demote_en && o_running) begin
            r_mode <= MODE_READY;
        end
    end
endmodule

// File: src/rate_monotonic_task_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_monotonic_task_scheduler_unit
// from accept to result strobe: register runs the 26-step divider, then a pass down
// the cell chain; yield or dispatching tick makes a chain pass; deregister or plain
// tick acts on the cells only; register with zero period skips all; one item at a time
// busy is high from accept until the result strobe; a new item is taken once busy is low
// the result is shown for one cycle on o_done; the receiver cannot stall
// synchronous active-low reset empties the table, clears time and the running task
// ----------------------------------------------------------------------------
module rate_monotonic_task_scheduler_unit #(
    parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rmts_pkg::t_in_item  i_item,
    output logic                o_done,
    output rmts_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [19:0]         i_cfg_data
);
    import rmts_pkg::*;
    localparam int IDX_W = $clog2(MAX_TASKS + 1);
    localparam logic [IDX_W-1:0] NONE = IDX_W'(MAX_TASKS);
    localparam logic [IDX_W-1:0] CHAIN_WAIT = IDX_W'(MAX_TASKS);

    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_CHK = 3'd2,
        S_ACT = 3'd3, S_DISP = 3'd4, S_OUT = 3'd5;

    logic [2:0] r_state;
    t_in_item r_in;
    logic [19:0] r_limit;
    logic [15:0] r_scale;
    logic [31:0] r_now, r_load;
    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] r_wait;
    logic [2:0] r_status;
    logic r_disp, r_done;
    t_out_item r_out;

    t_cell_cmd w_cmd;
    logic [MAX_TASKS:0] c_bv;
    logic [15:0] c_bp [MAX_TASKS+1];
    logic [IDX_W-1:0] c_bi [MAX_TASKS+1];
    logic [35:0] c_sum [MAX_TASKS+1];
    logic [MAX_TASKS-1:0] w_valid, w_match, w_due, w_runing, w_wr, w_run;
    logic [21:0] w_id [MAX_TASKS];
    logic [IDX_W-1:0] w_free;
    logic w_full;
    logic [4:0] w_used;
    logic w_div_done;
    logic [25:0] w_quot;
    logic w_chk_go, w_disp_go;

    rmts_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(start && !busy && i_item.op == OP_REG),
        .i_num(26'(i_item.compute_time) * 26'(PERMILLE)), .i_den(r_in.period),
        .o_done(w_div_done), .o_quot(w_quot)
    );

    assign c_bv[0] = 1'b0;
    assign c_bp[0] = '0;
    assign c_bi[0] = '0;
    assign c_sum[0] = {4'd0, r_load};

    // chain output is settled once every cell has passed it on
    assign w_chk_go = (r_state == S_CHK) && (r_wait == CHAIN_WAIT);
    assign w_disp_go = (r_state == S_DISP) && (r_wait == CHAIN_WAIT);

    always_comb begin
        w_cmd.yield_en = (r_state == S_ACT) && (r_in.op == OP_YIELD);
        w_cmd.dereg_en = (r_state == S_ACT) && (r_in.op == OP_DEREG);
        w_cmd.tick_en = (r_state == S_ACT) && (r_in.op == OP_TICK);
        w_cmd.demote_en = w_disp_go && c_bv[MAX_TASKS];
        w_cmd.id = r_in.task_id;
        w_cmd.now = r_now;
        w_cmd.scale = r_scale;
    end

    always_comb begin
        w_free = NONE;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
            if (!w_valid[i]) w_free = IDX_W'(i);
        w_full = (w_free == NONE);
        w_used = '0;
        for (int i = 0; i < MAX_TASKS; i++) w_used = w_used + 5'(w_valid[i]);
    end

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++) begin : g_cell
            assign w_wr[g] = w_chk_go && (w_free == IDX_W'(g)) && !w_full
                && (c_sum[MAX_TASKS] <= {16'd0, r_limit});
            assign w_run[g] = w_disp_go && c_bv[MAX_TASKS]
                && (c_bi[MAX_TASKS] == IDX_W'(g));
            rmts_cell #(.IDX_W(IDX_W)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_idx(IDX_W'(g)), .i_cmd(w_cmd),
                .i_wr(w_wr[g]), .i_wr_id(r_in.task_id), .i_wr_period(r_in.period),
                .i_wr_load(r_load), .i_run(w_run[g]),
                .i_best_v(c_bv[g]), .i_best_per(c_bp[g]), .i_best_idx(c_bi[g]),
                .i_sum(c_sum[g]),
                .o_best_v(c_bv[g+1]), .o_best_per(c_bp[g+1]), .o_best_idx(c_bi[g+1]),
                .o_sum(c_sum[g+1]), .o_valid(w_valid[g]), .o_match(w_match[g]),
                .o_due(w_due[g]), .o_running(w_runing[g]), .o_id(w_id[g])
            );
        end
    endgenerate

    logic w_rv;
    logic [21:0] w_rid;
    always_comb begin
        w_rv = 1'b0;
        w_rid = '0;
        for (int i = 0; i < MAX_TASKS; i++)
            if (r_cur == IDX_W'(i) && w_runing[i]) begin
                w_rv = 1'b1;
                w_rid = w_id[i];
            end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LIMIT_RESET;
            r_scale <= SCALE_RESET;
            r_now <= '0;
            r_cur <= NONE;
            r_wait <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LIMIT) r_limit <= i_cfg_data;
                else r_scale <= i_cfg_data[15:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in <= i_item;
                        r_disp <= 1'b0;
                        r_status <= ST_OK;
                        if (i_item.op == OP_REG) begin
                            if (i_item.period == 16'd0) begin
                                r_status <= ST_ZERO;
                                r_state <= S_OUT;
                            end else r_state <= S_DIV;
                        end else begin
                            if (i_item.op == OP_TICK) r_now <= r_now + 32'd1;
                            r_state <= S_ACT;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_load <= {6'd0, w_quot};
                        r_wait <= '0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_wait == CHAIN_WAIT) begin
                        if (w_full) r_status <= ST_FULL;
                        else if (c_sum[MAX_TASKS] > {16'd0, r_limit}) r_status <= ST_OVER;
                        r_state <= S_OUT;
                    end else r_wait <= r_wait + IDX_W'(1);
                end
                S_ACT: begin
                    if (r_in.op != OP_TICK && w_match == '0) r_status <= ST_UNKNOWN;
                    if (r_in.op == OP_DEREG) begin
                        for (int i = 0; i < MAX_TASKS; i++)
                            if (w_match[i] && r_cur == IDX_W'(i)) r_cur <= NONE;
                        r_state <= S_OUT;
                    end else if (r_in.op == OP_YIELD || w_due != '0) begin
                        r_disp <= 1'b1;
                        r_wait <= '0;
                        r_state <= S_DISP;
                    end else r_state <= S_OUT;
                end
                S_DISP: begin
                    if (r_wait == CHAIN_WAIT) begin
                        if (c_bv[MAX_TASKS]) r_cur <= c_bi[MAX_TASKS];
                        r_state <= S_OUT;
                    end else r_wait <= r_wait + IDX_W'(1);
                end
                S_OUT: begin
                    r_out.status <= r_status;
                    r_out.running_valid <= w_rv;
                    r_out.running_id <= w_rid;
                    r_out.dispatched <= r_disp;
                    r_out.tasks_used <= w_used;
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_item = r_out;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("result while working");
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= NONE) else $error("current slot out of range");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |=> o_done) else $error("missing result");
endmodule
